>>> src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, register indexes and fixed-point constants for the quaternion
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // field widths
  localparam int QW      = 16;             // quaternion component, Q2.14
  localparam int VW      = 32;             // vector component, Q16.16
  localparam int FRAC_Q  = 14;             // rounding shift after each product

  // first product q * (v, 0)
  localparam int P1_W    = QW + VW;        // one partial product
  localparam int S1_W    = P1_W + 2;       // sum of three terms
  localparam int TW      = S1_W - FRAC_Q;  // rounded t component

  // second product t * conj(q)
  localparam int P2_W    = TW + QW;        // one partial product
  localparam int S2_W    = P2_W + 2;       // sum of four terms
  localparam int RW      = S2_W - FRAC_Q;  // rounded r component

  // stream word widths
  localparam int IN_DW   = 3 * VW;
  localparam int OUT_DW  = 3 * VW;

  // configuration register indexes
  localparam int CFG_AW  = 2;
  localparam logic [CFG_AW-1:0] REG_ROT_X = 2'd0;
  localparam logic [CFG_AW-1:0] REG_ROT_Y = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROT_Z = 2'd2;
  localparam logic [CFG_AW-1:0] REG_ROT_W = 2'd3;

  localparam logic signed [QW-1:0] ROT_W_ONE = 16'sd16384;

  typedef logic signed [QW-1:0] qcomp_t;
  typedef logic signed [VW-1:0] vcomp_t;

endpackage

>>> src/quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates streamed Q16.16 vectors by the configured Q2.14 quaternion,
// r = q * (v, 0) * conj(q), rounded and saturated to 32 bits.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit first)                  | handshake
//  in_     | in  | tdata: vec_x, vec_y, vec_z              | tvalid/tready
//  out_    | out | tdata: out_x, out_y, out_z; tuser: sat  | tvalid/tready
//  cfg_    | in  | cfg_addr index, cfg_wdata 16 bit        | cfg_we, no wait
//
// Four register stages: first products, t rounding, second products,
// final rounding and clipping. One word per cycle while out_ is not stalled.
// Each stage holds its own valid bit and moves when the next stage is free,
// so a stall at out_ fills bubbles before in_tready drops.
// Reset (rst_n low, synchronous) clears valid bits and sets q to identity.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit
  import qvr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_DW-1:0]    in_tdata,   // vec_x, vec_y, vec_z

  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_DW-1:0]   out_tdata,  // out_x, out_y, out_z
  output logic                out_tuser,  // saturated

  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [QW-1:0]       cfg_wdata
);

  // configuration
  qcomp_t ux_r, uy_r, uz_r, w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ux_r <= '0;
      uy_r <= '0;
      uz_r <= '0;
      w_r  <= ROT_W_ONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROT_X: ux_r <= cfg_wdata;
        REG_ROT_Y: uy_r <= cfg_wdata;
        REG_ROT_Z: uz_r <= cfg_wdata;
        REG_ROT_W: w_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage flow control
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: partial products of q * (v, 0)
  vcomp_t vx, vy, vz;
  assign vx = in_tdata[VW-1:0];
  assign vy = in_tdata[2*VW-1:VW];
  assign vz = in_tdata[3*VW-1:2*VW];

  logic signed [P1_W-1:0] p1_r [12];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_r[0]  <= P1_W'(uy_r) * P1_W'(vz);   // tx
      p1_r[1]  <= P1_W'(uz_r) * P1_W'(vy);
      p1_r[2]  <= P1_W'(w_r)  * P1_W'(vx);
      p1_r[3]  <= P1_W'(uz_r) * P1_W'(vx);   // ty
      p1_r[4]  <= P1_W'(ux_r) * P1_W'(vz);
      p1_r[5]  <= P1_W'(w_r)  * P1_W'(vy);
      p1_r[6]  <= P1_W'(ux_r) * P1_W'(vy);   // tz
      p1_r[7]  <= P1_W'(uy_r) * P1_W'(vx);
      p1_r[8]  <= P1_W'(w_r)  * P1_W'(vz);
      p1_r[9]  <= P1_W'(ux_r) * P1_W'(vx);   // tw (negated dot)
      p1_r[10] <= P1_W'(uy_r) * P1_W'(vy);
      p1_r[11] <= P1_W'(uz_r) * P1_W'(vz);
    end
  end

  // stage 2: sum and round t, half LSB up then floor
  localparam logic signed [S1_W-1:0] HALF1 = S1_W'(1) <<< (FRAC_Q - 1);

  logic signed [S1_W-1:0] s1_x, s1_y, s1_z, s1_w;
  always_comb begin
    s1_x = S1_W'(p1_r[0]) - S1_W'(p1_r[1])  + S1_W'(p1_r[2])  + HALF1;
    s1_y = S1_W'(p1_r[3]) - S1_W'(p1_r[4])  + S1_W'(p1_r[5])  + HALF1;
    s1_z = S1_W'(p1_r[6]) - S1_W'(p1_r[7])  + S1_W'(p1_r[8])  + HALF1;
    s1_w = HALF1 - (S1_W'(p1_r[9]) + S1_W'(p1_r[10]) + S1_W'(p1_r[11]));
  end

  logic signed [TW-1:0] tx_r, ty_r, tz_r, tw_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      tx_r <= s1_x[S1_W-1:FRAC_Q];
      ty_r <= s1_y[S1_W-1:FRAC_Q];
      tz_r <= s1_z[S1_W-1:FRAC_Q];
      tw_r <= s1_w[S1_W-1:FRAC_Q];
    end
  end

  // stage 3: partial products of t * conj(q), conj signs folded into the sums
  logic signed [P2_W-1:0] p2_r [12];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      p2_r[0]  <= P2_W'(tz_r) * P2_W'(uy_r);   // rx = tz*uy - ty*uz + tx*w - tw*ux
      p2_r[1]  <= P2_W'(ty_r) * P2_W'(uz_r);
      p2_r[2]  <= P2_W'(tx_r) * P2_W'(w_r);
      p2_r[3]  <= P2_W'(tw_r) * P2_W'(ux_r);
      p2_r[4]  <= P2_W'(tx_r) * P2_W'(uz_r);   // ry = tx*uz - tz*ux + ty*w - tw*uy
      p2_r[5]  <= P2_W'(tz_r) * P2_W'(ux_r);
      p2_r[6]  <= P2_W'(ty_r) * P2_W'(w_r);
      p2_r[7]  <= P2_W'(tw_r) * P2_W'(uy_r);
      p2_r[8]  <= P2_W'(ty_r) * P2_W'(ux_r);   // rz = ty*ux - tx*uy + tz*w - tw*uz
      p2_r[9]  <= P2_W'(tx_r) * P2_W'(uy_r);
      p2_r[10] <= P2_W'(tz_r) * P2_W'(w_r);
      p2_r[11] <= P2_W'(tw_r) * P2_W'(uz_r);
    end
  end

  // stage 4: sum, round, clip
  localparam logic signed [S2_W-1:0] HALF2 = S2_W'(1) <<< (FRAC_Q - 1);

  logic signed [S2_W-1:0] s2 [3];
  logic signed [RW-1:0]   rr [3];
  logic [VW-1:0]          clip [3];
  logic [2:0]             over;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2[i] = S2_W'(p2_r[4*i])     - S2_W'(p2_r[4*i + 1])
            + S2_W'(p2_r[4*i + 2]) - S2_W'(p2_r[4*i + 3]) + HALF2;
      rr[i] = s2[i][S2_W-1:FRAC_Q];
      // in range when all bits above the 32-bit sign match it
      over[i] = !((&rr[i][RW-1:VW-1]) || !(|rr[i][RW-1:VW-1]));
      if (!over[i])
        clip[i] = rr[i][VW-1:0];
      else if (rr[i][RW-1])
        clip[i] = {1'b1, {(VW-1){1'b0}}};
      else
        clip[i] = {1'b0, {(VW-1){1'b1}}};
    end
  end

  logic [OUT_DW-1:0] out_data_r;
  logic              out_sat_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_data_r <= {clip[2], clip[1], clip[0]};
      out_sat_r  <= |over;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

>>> tb/sv/tb_quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate_unit
// Streams Q16.16 vectors through the rotation unit under several quaternion
// settings and idle/stall mixes; each output word is checked against a
// local fixed-point model of q * (v, 0) * conj(q).
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate_unit;
  import qvr_pkg::*;

  localparam int IDLE_LIMIT = 2000;  // cycles without any accepted word or cfg write
  localparam int MAX_PRINTS = 30;

  typedef struct packed {
    vcomp_t x;
    vcomp_t y;
    vcomp_t z;
    logic   sat;
  } rot_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;   // vec_x, vec_y, vec_z
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;  // out_x, out_y, out_z
  logic              out_tuser;  // saturated
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [QW-1:0]     cfg_wdata;

  // model copy of the quaternion registers
  qcomp_t q_x = '0, q_y = '0, q_z = '0, q_w = ROT_W_ONE;

  rot_result_t pending_rot[$];
  int err_count  = 0;
  int idle_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  quaternion_vector_rotate_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round half up, then drop FRAC_Q fraction bits
  function automatic longint round_frac(longint v);
    return (v + (longint'(1) <<< (FRAC_Q - 1))) >>> FRAC_Q;
  endfunction

  function automatic rot_result_t rotate_vec(vcomp_t vx, vcomp_t vy, vcomp_t vz);
    longint ux, uy, uz, w, px, py, pz;
    longint tx, ty, tz, tw;
    longint r[3];
    rot_result_t res;
    ux = q_x; uy = q_y; uz = q_z; w = q_w;
    px = vx;  py = vy;  pz = vz;
    tx = round_frac(uy * pz - uz * py + w * px);
    ty = round_frac(uz * px - ux * pz + w * py);
    tz = round_frac(ux * py - uy * px + w * pz);
    tw = round_frac(-(ux * px + uy * py + uz * pz));
    // conj(q) vector part is -u
    r[0] = round_frac(ty * (-uz) - tz * (-uy) + tx * w + (-ux) * tw);
    r[1] = round_frac(tz * (-ux) - tx * (-uz) + ty * w + (-uy) * tw);
    r[2] = round_frac(tx * (-uy) - ty * (-ux) + tz * w + (-uz) * tw);
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (r[i] > 64'sd2147483647) begin
        r[i] = 64'sd2147483647;
        res.sat = 1'b1;
      end else if (r[i] < -64'sd2147483648) begin
        r[i] = -64'sd2147483648;
        res.sat = 1'b1;
      end
    end
    res.x = r[0][VW-1:0];
    res.y = r[1][VW-1:0];
    res.z = r[2][VW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("MISMATCH %0s: got %h want %h (t=%0t)", what, got, want, $time);
  endtask

  // scoreboard, model registers and watchdog
  always @(posedge clk) begin
    rot_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_rot.size() == 0) begin
          report_mismatch("unexpected word", out_tdata[VW-1:0], '0);
        end else begin
          want = pending_rot.pop_front();
          if (out_tdata[VW-1:0] !== want.x)
            report_mismatch("out_x", out_tdata[VW-1:0], want.x);
          if (out_tdata[2*VW-1:VW] !== want.y)
            report_mismatch("out_y", out_tdata[2*VW-1:VW], want.y);
          if (out_tdata[3*VW-1:2*VW] !== want.z)
            report_mismatch("out_z", out_tdata[3*VW-1:2*VW], want.z);
          if (out_tuser !== want.sat)
            report_mismatch("saturated", {31'b0, out_tuser}, {31'b0, want.sat});
        end
      end
      if (in_tvalid && in_tready)
        pending_rot.push_back(rotate_vec(in_tdata[VW-1:0], in_tdata[2*VW-1:VW],
                                         in_tdata[3*VW-1:2*VW]));
      if (cfg_we) begin
        case (cfg_addr)
          REG_ROT_X: q_x <= cfg_wdata;
          REG_ROT_Y: q_y <= cfg_wdata;
          REG_ROT_Z: q_z <= cfg_wdata;
          REG_ROT_W: q_w <= cfg_wdata;
          default: ;
        endcase
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_count <= 0;
      end else if (idle_count + 1 >= IDLE_LIMIT) begin
        $display("tb_quaternion_vector_rotate_unit: errors");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_vec(vcomp_t vx, vcomp_t vy, vcomp_t vz);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vz, vy, vx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_rot.size() != 0) @(posedge clk);
  endtask

  task automatic load_quat(qcomp_t x, qcomp_t y, qcomp_t z, qcomp_t w);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ROT_X;
    cfg_wdata <= x;
    @(posedge clk);
    cfg_addr  <= REG_ROT_Y;
    cfg_wdata <= y;
    @(posedge clk);
    cfg_addr  <= REG_ROT_Z;
    cfg_wdata <= z;
    @(posedge clk);
    cfg_addr  <= REG_ROT_W;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic vcomp_t rand_comp();
    case ($urandom_range(3))
      0: return vcomp_t'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return '0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return vcomp_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
    endcase
  endfunction

  function automatic qcomp_t rand_qcomp(int kind);
    case (kind)
      0: return qcomp_t'($urandom_range(0, 16'hffff));
      1: begin
        case ($urandom_range(4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return '0;
          3: return ROT_W_ONE;
          default: return -ROT_W_ONE;
        endcase
      end
      default: return qcomp_t'(int'($urandom_range(0, 24000)) - 12000);
    endcase
  endfunction

  // reset registers give the identity rotation
  task automatic test_identity();
    send_vec('0, '0, '0);
    send_vec(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_vec(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_vec(-32'sd1, 32'sd1, -32'sd1);
    send_vec(32'sh00010000, 32'shffff0000, 32'sh55555555);
    send_vec(32'shaaaaaaaa, 32'sh12345678, 32'sh87654321);
  endtask

  // extreme quaternions drive large components into clipping
  task automatic test_saturation();
    load_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vec(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_vec(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_vec(32'sd100, -32'sd200, 32'sd300);
    load_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_vec(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vec(32'sh7fffffff, 32'sh80000000, 32'sh00000001);
    send_vec(-32'sd1, -32'sd1, -32'sd1);
  endtask

  // zero quaternion, then a tiny scalar so the first rounding hits its halfway points
  task automatic test_zero_and_rounding();
    load_quat('0, '0, '0, '0);
    send_vec(32'sh7fffffff, 32'sh80000000, 32'sh12345678);
    load_quat('0, '0, '0, 16'sd1);
    send_vec(32'sd8192, -32'sd8192, -32'sd8193);
    send_vec(32'sd8191, 32'sd24576, -32'sd24576);
    load_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_vec(32'sd8192, 32'sd16384, -32'sd8192);
  endtask

  task automatic test_random_stream();
    int send_mix[4] = '{0, 71, 0, 22};
    int recv_mix[4] = '{0, 0, 71, 22};
    int kind;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      for (int blk = 0; blk < 5; blk++) begin
        if (blk == 0) begin
          case (ph)
            0: load_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
            1: load_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
            2: load_quat('0, '0, 16'sd11585, 16'sd11585);  // 90 deg about z
            default: load_quat('0, '0, '0, 16'sh8000);
          endcase
        end else begin
          kind = $urandom_range(4);
          load_quat(rand_qcomp(kind), rand_qcomp(kind), rand_qcomp(kind), rand_qcomp(kind));
        end
        for (int i = 0; i < 55; i++)
          send_vec(rand_comp(), rand_comp(), rand_comp());
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_ROT_X;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_identity();
    test_saturation();
    test_zero_and_rounding();
    test_random_stream();

    wait_drain();
    repeat (8) @(posedge clk);  // catch stray words past the pipeline depth
    if (err_count == 0)
      $display("tb_quaternion_vector_rotate_unit: clean");
    else
      $display("tb_quaternion_vector_rotate_unit: errors");
    $finish;
  end

endmodule

>>> filelist.f
src/qvr_pkg.sv
src/quaternion_vector_rotate_unit.sv
tb/sv/tb_quaternion_vector_rotate_unit.sv
